[hw/rtl/pfa_pkg.sv]
// Shared types, operation codes and default sizes of the page frame allocator.
package pfa_pkg;

  // Default sizes of the frame map and the page table.
  localparam int unsigned FRAME_COUNT_DEF = 128;
  localparam int unsigned PAGE_COUNT_DEF  = 256;

  // Operation codes of a request.
  localparam logic [1:0] OP_FAULT = 2'd0;
  localparam logic [1:0] OP_AGING = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] page;
    logic [7:0] aging_value;
    logic [6:0] query_frame;
  } req_t;

  typedef struct packed {
    logic [6:0] frame;
    logic       evicted;
    logic [7:0] evict_page;
    logic       no_victim;
    logic       owner_valid;
    logic [7:0] owner_page;
  } rsp_t;

endpackage

[hw/rtl/page_frame_allocator_aging_victim.sv]
// Page frame allocator with aging-counter victim selection (top level).
//
// Requests enter on the in channel (valid/ready) and carry an operation:
// a page fault, a write of a page's aging counter, or a query for the owner
// of a physical frame. Every request produces exactly one response on the
// out channel (valid/ready), in request order.
//
// Path to the output register: an aging write goes straight to the response
// state; a frame-owner query first passes the query state, and a fault the
// check state, where it hits a mapped page or takes a free frame. A fault with
// no free frame scans the page table RAMs one entry per cycle, then evicts and
// maps; that scan sets the worst case. One request is worked on at a time.
//
// After reset the block walks the page table once to mark every page invalid
// and zero its aging counter; in_ready_o stays low until the walk is done.
// Frames are handed out in ascending order and are never returned, so a fill
// counter stands in for the per-frame free bits.
//
// A stalled response waits in the output register; the block still takes the
// next request and holds its response until the output register is free.
module page_frame_allocator_aging_victim #(
  parameter int unsigned FRAME_COUNT = pfa_pkg::FRAME_COUNT_DEF,
  parameter int unsigned PAGE_COUNT  = pfa_pkg::PAGE_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pfa_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pfa_pkg::rsp_t out_rsp_o
);

  localparam int unsigned FW   = $clog2(FRAME_COUNT);
  localparam int unsigned PW   = $clog2(PAGE_COUNT);
  localparam int unsigned CNTW = $clog2(FRAME_COUNT + 1);
  localparam int unsigned MW   = FW + 1;  // page map entry: {valid, frame}

  // Sequencer states.
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHECK    = 4'd2;
  localparam logic [3:0] S_QUERY    = 4'd3;
  localparam logic [3:0] S_SCAN     = 4'd4;
  localparam logic [3:0] S_SCAN_END = 4'd5;
  localparam logic [3:0] S_EVICT    = 4'd6;
  localparam logic [3:0] S_MAP      = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [PW-1:0]   cnt_q, cnt_d;
  logic [CNTW-1:0] fill_q, fill_d;
  logic            out_valid_q, out_valid_d;
  logic            dv_q, dv_d;
  logic            found_q, found_d;

  pfa_pkg::req_t   req_q, req_d;
  pfa_pkg::rsp_t   res_q, res_d;
  pfa_pkg::rsp_t   out_q, out_d;
  logic            qok_q, qok_d;
  logic [7:0]      best_age_q, best_age_d;
  logic [PW-1:0]   best_idx_q, best_idx_d;
  logic [FW-1:0]   best_frame_q, best_frame_d;
  logic [PW-1:0]   didx_q, didx_d;

  // RAM ports.
  logic            map_we;
  logic [PW-1:0]   map_waddr, map_raddr;
  logic [MW-1:0]   map_wdata, map_rdata;
  logic            aging_we;
  logic [PW-1:0]   aging_waddr, aging_raddr;
  logic [7:0]      aging_wdata, aging_rdata;
  logic            owner_we;
  logic [FW-1:0]   owner_waddr, owner_raddr;
  logic [7:0]      owner_wdata, owner_rdata;

  logic            in_fire;
  logic            in_pg_ok;
  logic [PW-1:0]   in_pg_idx;
  logic [PW-1:0]   pg_idx;
  logic [FW-1:0]   new_frame;

  // Page table: valid bit and frame number per page.
  pfa_ram #(.Width(MW), .Depth(PAGE_COUNT)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Aging counter per page.
  pfa_ram #(.Width(8), .Depth(PAGE_COUNT)) u_aging_ram (
    .clk_i   (clk_i),
    .we_i    (aging_we),
    .waddr_i (aging_waddr),
    .wdata_i (aging_wdata),
    .raddr_i (aging_raddr),
    .rdata_o (aging_rdata)
  );

  // Owning page per physical frame; only used for frames below the fill count.
  pfa_ram #(.Width(8), .Depth(FRAME_COUNT)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .waddr_i (owner_waddr),
    .wdata_i (owner_wdata),
    .raddr_i (owner_raddr),
    .rdata_o (owner_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign in_pg_ok    = (32'(in_req_i.page) < PAGE_COUNT);
  assign in_pg_idx   = PW'(in_req_i.page);
  assign pg_idx      = PW'(req_q.page);
  assign new_frame   = fill_q[FW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q;
    dv_d         = dv_q;
    found_d      = found_q;
    req_d        = req_q;
    res_d        = res_q;
    out_d        = out_q;
    qok_d        = qok_q;
    best_age_d   = best_age_q;
    best_idx_d   = best_idx_q;
    best_frame_d = best_frame_q;
    didx_d       = didx_q;

    map_we      = 1'b0;
    map_waddr   = '0;
    map_wdata   = '0;
    map_raddr   = '0;
    aging_we    = 1'b0;
    aging_waddr = '0;
    aging_wdata = '0;
    aging_raddr = '0;
    owner_we    = 1'b0;
    owner_waddr = '0;
    owner_wdata = '0;
    owner_raddr = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Victim search: the RAM data of the entry read last cycle arrives now.
    // A strict compare keeps the lowest page index on equal aging counters.
    if (dv_q && map_rdata[FW] && (!found_q || aging_rdata < best_age_q)) begin
      found_d      = 1'b1;
      best_age_d   = aging_rdata;
      best_idx_d   = didx_q;
      best_frame_d = map_rdata[FW-1:0];
    end

    case (state_q)
      S_CLEAR: begin
        map_we      = 1'b1;
        map_waddr   = cnt_q;
        aging_we    = 1'b1;
        aging_waddr = cnt_q;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == PW'(PAGE_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_d = in_req_i;
          res_d = '0;
          // Frames below the fill count are owned; the count never exceeds
          // FRAME_COUNT, so this also rejects out-of-range frames.
          qok_d = (32'(in_req_i.query_frame) < 32'(fill_q));
          case (in_req_i.op)
            pfa_pkg::OP_FAULT: begin
              if (in_pg_ok) begin
                map_raddr = in_pg_idx;
                state_d   = S_CHECK;
              end else begin
                res_d.no_victim = 1'b1;
                state_d         = S_RESP;
              end
            end
            pfa_pkg::OP_AGING: begin
              aging_we    = in_pg_ok;
              aging_waddr = in_pg_idx;
              aging_wdata = in_req_i.aging_value;
              state_d     = S_RESP;
            end
            pfa_pkg::OP_QUERY: begin
              owner_raddr = FW'(in_req_i.query_frame);
              state_d     = S_QUERY;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_QUERY: begin
        if (qok_q) begin
          res_d.owner_valid = 1'b1;
          res_d.owner_page  = owner_rdata;
        end
        state_d = S_RESP;
      end
      S_CHECK: begin
        if (map_rdata[FW]) begin
          // Already mapped: report its frame, change nothing.
          res_d.frame = 7'(map_rdata[FW-1:0]);
          state_d     = S_RESP;
        end else if (fill_q < CNTW'(FRAME_COUNT)) begin
          owner_we    = 1'b1;
          owner_waddr = new_frame;
          owner_wdata = req_q.page;
          map_we      = 1'b1;
          map_waddr   = pg_idx;
          map_wdata   = {1'b1, new_frame};
          fill_d      = fill_q + 1'b1;
          res_d.frame = 7'(new_frame);
          state_d     = S_RESP;
        end else begin
          cnt_d   = '0;
          found_d = 1'b0;
          dv_d    = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        map_raddr   = cnt_q;
        aging_raddr = cnt_q;
        dv_d        = 1'b1;
        didx_d      = cnt_q;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == PW'(PAGE_COUNT - 1)) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        dv_d    = 1'b0;
        state_d = S_EVICT;
      end
      S_EVICT: begin
        if (!found_q) begin
          res_d.no_victim = 1'b1;
          state_d         = S_RESP;
        end else begin
          map_we      = 1'b1;
          map_waddr   = best_idx_q;
          map_wdata   = {1'b0, best_frame_q};
          owner_we    = 1'b1;
          owner_waddr = best_frame_q;
          owner_wdata = req_q.page;
          state_d     = S_MAP;
        end
      end
      S_MAP: begin
        map_we           = 1'b1;
        map_waddr        = pg_idx;
        map_wdata        = {1'b1, best_frame_q};
        res_d.frame      = 7'(best_frame_q);
        res_d.evicted    = 1'b1;
        res_d.evict_page = 8'(best_idx_q);
        state_d          = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      dv_q        <= dv_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    res_q        <= res_d;
    out_q        <= out_d;
    qok_q        <= qok_d;
    best_age_q   <= best_age_d;
    best_idx_q   <= best_idx_d;
    best_frame_q <= best_frame_d;
    didx_q       <= didx_d;
  end

endmodule

[hw/rtl/pfa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
